### sv/u8lv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8lv_pkg;

    // Bytes and masks used by the decoder
    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_COLON   = 8'h3A;
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_CODE   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_CODE   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_CODE   = 8'hF0;
    localparam logic [1:0] CONT_TAG     = 2'b10;

    // Code point limits
    localparam logic [20:0] CP_MIN_2    = 21'h00080;
    localparam logic [20:0] CP_MIN_3    = 21'h00800;
    localparam logic [20:0] CP_MIN_4    = 21'h10000;
    localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;

    // Sequence lengths
    localparam logic [2:0] SEQ_NONE     = 3'd0;
    localparam logic [2:0] SEQ_1        = 3'd1;
    localparam logic [2:0] SEQ_2        = 3'd2;
    localparam logic [2:0] SEQ_3        = 3'd3;
    localparam logic [2:0] SEQ_4        = 3'd4;

    typedef struct packed {
        logic [1:0]  pending;
        logic [2:0]  seq_len;
        logic [20:0] cp_bits;
        logic        error;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_IDLE = '{
        pending:    2'd0,
        seq_len:    SEQ_NONE,
        cp_bits:    21'd0,
        error:      1'b0
    };

endpackage

`default_nettype wire

### sv/u8lv_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// One decode step: state plus one registered item gives the next state and
// the verdict for a final item.
module u8lv_decode
    import u8lv_pkg::*;
(
    input  wire dec_state_t  cur_state,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_string,
    input  wire logic        string_empty,
    output dec_state_t       next_state,
    output logic             accepted
);

    dec_state_t  after_byte;
    logic [20:0] cp_shift;
    logic [1:0]  pend_dec;

    always_comb
    begin
        after_byte = cur_state;
        cp_shift   = {cur_state.cp_bits[14:0], data_byte[5:0]};
        pend_dec   = cur_state.pending - 2'd1;

        if (!string_empty && !cur_state.error)
        begin
            if (cur_state.pending == 2'd0)
            begin
                // lead byte
                if (data_byte inside {BYTE_NUL, BYTE_COLON})
                begin
                    after_byte.error = 1'b1;
                end
                else if (data_byte < ASCII_LIMIT)
                begin
                    after_byte.seq_len = SEQ_1;
                    after_byte.cp_bits = {13'd0, data_byte};
                end
                else if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
                begin
                    after_byte.seq_len = SEQ_2;
                    after_byte.cp_bits = {16'd0, data_byte[4:0]};
                    after_byte.pending = 2'd1;
                end
                else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
                begin
                    after_byte.seq_len = SEQ_3;
                    after_byte.cp_bits = {17'd0, data_byte[3:0]};
                    after_byte.pending = 2'd2;
                end
                else if ((data_byte & LEAD4_MASK) == LEAD4_CODE)
                begin
                    after_byte.seq_len = SEQ_4;
                    after_byte.cp_bits = {18'd0, data_byte[2:0]};
                    after_byte.pending = 2'd3;
                end
                else
                begin
                    after_byte.error = 1'b1;
                end
            end
            else if (data_byte[7:6] != CONT_TAG)
            begin
                after_byte.error = 1'b1;
            end
            else
            begin
                after_byte.cp_bits = cp_shift;
                after_byte.pending = pend_dec;
                if (pend_dec == 2'd0)
                begin
                    // sequence complete: overlong, surrogate and range checks
                    if ((cur_state.seq_len == SEQ_2 && cp_shift < CP_MIN_2) ||
                        (cur_state.seq_len == SEQ_3 && cp_shift < CP_MIN_3) ||
                        (cur_state.seq_len == SEQ_4 && cp_shift < CP_MIN_4) ||
                        (cp_shift inside {[CP_SURR_LO:CP_SURR_HI]}) ||
                        (cp_shift > CP_MAX))
                    begin
                        after_byte.error = 1'b1;
                    end
                end
            end
        end

        accepted   = !after_byte.error && (after_byte.pending == 2'd0);
        next_state = end_of_string ? DEC_STATE_IDLE : after_byte;
    end

endmodule

`default_nettype wire

### sv/utf8_localpart_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Payload                                         | Item
// ----------+-----+-------------------------------------------------+----------------------
// s_axis    | in  | tdata[7:0] data_byte, tlast end_of_string,      | one byte (or none)
//           |     | tuser string_empty                              |
// m_axis    | out | tdata[0] accepted, tdata[7:1] zero              | one verdict per string
//
// One item a cycle while no final item waits on a stalled result. Each item
// is held in the input register, where the decode step updates the string
// state and, on a final item, loads the verdict into the output register.
// Asynchronous active-low reset clears the string state and both valids.
// A stalled result holds the output register; only a final item then waits
// in the input register, bytes that give no verdict keep flowing.

module utf8_localpart_validator_unit
    import u8lv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // end_of_string
    input  wire logic       s_axis_tuser,   // [0] string_empty

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] accepted, [7:1] zero
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // string state
    dec_state_t state_reg;
    dec_state_t state_next;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_acc_reg;
    logic       out_acc_next;

    logic       dec_accepted;
    logic       advance;
    logic       in_take;

    u8lv_decode u_decode (
        .cur_state     (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_string (in_last_reg),
        .string_empty  (in_empty_reg),
        .next_state    (state_next),
        .accepted      (dec_accepted)
    );

    // The item in the input register moves on unless it carries a verdict
    // and the result register is still held by the sink.
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_acc_next   = dec_accepted;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= DEC_STATE_IDLE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
        out_acc_reg <= out_acc_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_acc_reg};

endmodule

`default_nettype wire

### sv/u8lv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u8lv_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // verdicts owed: final items taken minus results delivered
    logic [1:0] owed_reg;
    logic [1:0] owed_next;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        owed_next = owed_reg + {1'b0, s_fire && s_axis_tlast} - {1'b0, m_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= 2'd0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    // no verdict without a final item behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (owed_reg != 2'd0))
        else $error("result shown with no final item outstanding");

    // at most one verdict in the input register and one in the output register
    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg != 2'd3)
        else $error("too many verdicts in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result padding not zero");

endmodule

bind utf8_localpart_validator_unit u8lv_checker u_u8lv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
